// File: rtl/dual_stack_shared_memory_assert.svh
// assertion macros for the dual stack shared memory block
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef DUAL_STACK_SHARED_MEMORY_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_ASSERT_SVH

// same-cycle implication
`define DSSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dssm assertion failed");

// next-cycle implication
`define DSSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dssm assertion failed");

`endif

// File: rtl/dssm_pkg.sv
// shared constants and types for the dual stack shared memory block
// no dependencies
package dssm_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_LOW  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_HIGH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LOW   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HIGH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_LOW  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              rd;
        logic [STAT_W-1:0] status;
        logic              low_empty;
    } t_pend;

endpackage

// File: rtl/dssm_ram.sv
// single-port synchronous ram, registered read data
// generic, no package dependency
module dssm_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dual_stack_shared_memory.sv
// top level: two stacks in one ram, command decode, counters, output register
// depends on dssm_pkg, dssm_ram and dual_stack_shared_memory_assert.svh
// usage:
//   slave channel carries one command per transfer: tuser holds the command
//   code, tdata the word to push (ignored by pop and peek).
//   master channel returns exactly one result per command: tdata holds the
//   popped or peeked word (all ones when there is none), tuser holds status
//   and the low-stack-empty flag.
//   result path: each result passes through the ram read register, with the
//   pending register beside it, and then through the output register on its
//   way to the master side.
//   throughput: one command per cycle unless stalled; counters update at the command
//   transfer, so the next command sees the new stack tops at once.
//   stall: when the receiver holds tready low, the output register and the
//   ram stage fill and tready on the slave side drops until a result leaves.
//   reset: both stacks empty, no results pending; ram contents are not
//   cleared and are never read before being written.
module dual_stack_shared_memory (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // push_value[31:0]
    input  logic [2:0]  i_s_axis_tuser,  // command[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // read_value[31:0]
    output logic [2:0]  o_m_axis_tuser   // status[1:0], low_is_empty[2]
);

    `include "dual_stack_shared_memory_assert.svh"

    localparam int CNT_W  = dssm_pkg::CNT_W;
    localparam int ADDR_W = dssm_pkg::ADDR_W;
    localparam int DATA_W = dssm_pkg::DATA_W;

    logic [CNT_W-1:0]  r_low_cnt, n_low_cnt;
    logic [CNT_W-1:0]  r_high_cnt, n_high_cnt;
    logic              r_p_valid;
    dssm_pkg::t_pend   r_p, n_p;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [2:0]        r_out_user;

    logic              out_free;
    logic              in_xfer;
    logic              full;
    logic [CNT_W:0]    used;
    logic              mem_en, mem_we;
    logic [CNT_W-1:0]  mem_addr_w;
    logic [DATA_W-1:0] mem_rdata;
    logic              empty_pop;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_p_valid || out_free;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign used            = {1'b0, r_low_cnt} + {1'b0, r_high_cnt};
    assign full            = used >= (CNT_W+1)'(dssm_pkg::DEPTH);

    always_comb begin
        n_low_cnt     = r_low_cnt;
        n_high_cnt    = r_high_cnt;
        n_p.rd        = 1'b0;
        n_p.status    = dssm_pkg::ST_OK;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr_w    = r_low_cnt;
        unique case (i_s_axis_tuser)
            dssm_pkg::CMD_PUSH_LOW: begin
                if (full) begin
                    n_p.status = dssm_pkg::ST_FULL;
                end else begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr_w = r_low_cnt;
                    n_low_cnt  = r_low_cnt + CNT_W'(1);
                end
            end
            dssm_pkg::CMD_PUSH_HIGH: begin
                if (full) begin
                    n_p.status = dssm_pkg::ST_FULL;
                end else begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr_w = CNT_W'(dssm_pkg::DEPTH - 1) - r_high_cnt;
                    n_high_cnt = r_high_cnt + CNT_W'(1);
                end
            end
            dssm_pkg::CMD_POP_LOW: begin
                if (r_low_cnt == '0) begin
                    n_p.status = dssm_pkg::ST_EMPTY;
                end else begin
                    mem_en     = 1'b1;
                    n_p.rd     = 1'b1;
                    mem_addr_w = r_low_cnt - CNT_W'(1);
                    n_low_cnt  = r_low_cnt - CNT_W'(1);
                end
            end
            dssm_pkg::CMD_POP_HIGH: begin
                if (r_high_cnt == '0) begin
                    n_p.status = dssm_pkg::ST_EMPTY;
                end else begin
                    mem_en     = 1'b1;
                    n_p.rd     = 1'b1;
                    mem_addr_w = CNT_W'(dssm_pkg::DEPTH) - r_high_cnt;
                    n_high_cnt = r_high_cnt - CNT_W'(1);
                end
            end
            dssm_pkg::CMD_PEEK_LOW: begin
                if (r_low_cnt == '0) begin
                    n_p.status = dssm_pkg::ST_EMPTY;
                end else begin
                    mem_en     = 1'b1;
                    n_p.rd     = 1'b1;
                    mem_addr_w = r_low_cnt - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_p.low_empty = (n_low_cnt == '0);
    end

    dssm_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (dssm_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en && in_xfer),
        .i_we    (mem_we),
        .i_addr  (mem_addr_w[ADDR_W-1:0]),
        .i_wdata (i_s_axis_tdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt   <= '0;
            r_high_cnt  <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_low_cnt  <= n_low_cnt;
                r_high_cnt <= n_high_cnt;
                r_p        <= n_p;
            end
            if (in_xfer) begin
                r_p_valid <= 1'b1;
            end else if (out_free) begin
                r_p_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_p_valid;
                if (r_p_valid) begin
                    r_out_data <= r_p.rd ? mem_rdata : '1;
                    r_out_user <= {r_p.low_empty, r_p.status};
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign empty_pop = in_xfer && (i_s_axis_tuser == dssm_pkg::CMD_POP_LOW) && (r_low_cnt == '0);

    `DSSM_ASSERT_NOW(a_no_overfill, 1'b1, used <= (CNT_W+1)'(dssm_pkg::DEPTH))
    `DSSM_ASSERT_NEXT(a_push_grows, in_xfer && mem_we, used == $past(used) + (CNT_W+1)'(1))
    `DSSM_ASSERT_NEXT(a_empty_pop, empty_pop, r_p.status == dssm_pkg::ST_EMPTY && !r_p.rd)
    `DSSM_ASSERT_NEXT(a_rdata_hold, r_p_valid && r_p.rd && !out_free, $stable(mem_rdata))

endmodule
